// ===== hdl/quaternion_to_euler_angles_top_defines.svh =====
// Assertion macros for the quaternion to Euler angle pipeline.
// Included by the top-level RTL file, which checks its own logic; no other dependencies.
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define QTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define QTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QTE_ASSERT_IMP(label, ante, cons, msg)
`define QTE_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/qte_pkg.sv =====
// Shared constants, types and the CORDIC angle table for the quaternion to
// Euler angle pipeline. No dependencies.
package qte_pkg;

    localparam int Q_W            = 16;   // quaternion component width
    localparam int MW             = 35;   // rotation matrix term width (Q.28)
    localparam int R20_W          = 30;   // clamped r20 width
    localparam int RAD_W          = 57;   // sqrt radicand width
    localparam int SQ_W           = 58;   // sqrt working width
    localparam int SQRT_STEPS     = 29;   // one result bit per stage
    localparam int ROOT_W         = 29;
    localparam int CW             = 37;   // CORDIC x/y width
    localparam int ZW             = 25;   // CORDIC angle width (Q.20)
    localparam int ANGLE_W        = 16;
    localparam int PITCH_W        = 15;

    localparam int CORDIC_ITERATIONS = 14;
    localparam int ATAN_TABLE_LEN    = 24;
    localparam int CORDIC_STAGES     = (CORDIC_ITERATIONS > ATAN_TABLE_LEN) ?
                                       ATAN_TABLE_LEN : CORDIC_ITERATIONS;
    // pre-rotation stage, iterations, rounding stage
    localparam int CORDIC_LAT        = CORDIC_STAGES + 2;

    localparam int PI_Q20            = 3294199;
    localparam int LIMIT_PI_Q13      = 25736;
    localparam int LIMIT_HALF_PI_Q13 = 12868;
    localparam int ONE_Q28           = 268435456;

    // payload carried alongside the square root
    typedef struct packed {
        logic signed [MW-1:0]    r00;
        logic signed [MW-1:0]    r10;
        logic signed [MW-1:0]    r21;
        logic signed [MW-1:0]    r22;
        logic signed [R20_W-1:0] r20;
        logic                    clamped;
    } side_t;

    // per-instance CORDIC output handling
    typedef struct packed {
        logic negate;
        logic half_range;
    } cordic_mode_t;

    // atan(2^-i) in Q.20, rounded to nearest
    function automatic logic [19:0] atan_q20(input int idx);
        logic [19:0] val;
        case (idx)
            0:       val = 20'd823550;
            1:       val = 20'd486170;
            2:       val = 20'd256879;
            3:       val = 20'd130396;
            4:       val = 20'd65451;
            5:       val = 20'd32757;
            6:       val = 20'd16383;
            7:       val = 20'd8192;
            8:       val = 20'd4096;
            9:       val = 20'd2048;
            10:      val = 20'd1024;
            11:      val = 20'd512;
            12:      val = 20'd256;
            13:      val = 20'd128;
            14:      val = 20'd64;
            15:      val = 20'd32;
            16:      val = 20'd16;
            17:      val = 20'd8;
            18:      val = 20'd4;
            19:      val = 20'd2;
            20:      val = 20'd1;
            default: val = 20'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/qte_matrix.sv =====
// Rotation matrix terms, r20 clamp and the radicand 1 - r20^2, five stages.
// Depends on qte_pkg.
module qte_matrix import qte_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [Q_W-1:0] q0,
    input  logic signed [Q_W-1:0] q1,
    input  logic signed [Q_W-1:0] q2,
    input  logic signed [Q_W-1:0] q3,
    output logic                  out_valid,
    output side_t                 side,
    output logic [RAD_W-1:0]      radicand
);

    logic [4:0] vld_reg;

    logic signed [2*Q_W-1:0] p00_reg, p11_reg, p22_reg, p33_reg;
    logic signed [2*Q_W-1:0] p12_reg, p03_reg, p13_reg, p02_reg, p01_reg, p23_reg;

    logic signed [MW-1:0] r00_reg, r10_reg, r20_reg, r21_reg, r22_reg;

    side_t s3_reg, s4_reg, s5_reg;
    logic [ROOT_W-1:0] abs_reg;
    logic [27:0] hh_reg;
    logic [28:0] hl_reg;
    logic [29:0] ll_reg;
    logic [RAD_W-1:0] rad_reg;

    side_t s3_next;
    logic [ROOT_W-1:0] abs_next;
    logic [RAD_W-1:0] sq_next;

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // clamp r20 to +-1.0 and take its magnitude
    always_comb
    begin
        s3_next.r00 = r00_reg;
        s3_next.r10 = r10_reg;
        s3_next.r21 = r21_reg;
        s3_next.r22 = r22_reg;
        if (r20_reg > MW'(ONE_Q28))
        begin
            s3_next.r20     = R20_W'(ONE_Q28);
            s3_next.clamped = 1'b1;
            abs_next        = ROOT_W'(ONE_Q28);
        end
        else if (r20_reg < -MW'(ONE_Q28))
        begin
            s3_next.r20     = -R20_W'(ONE_Q28);
            s3_next.clamped = 1'b1;
            abs_next        = ROOT_W'(ONE_Q28);
        end
        else
        begin
            s3_next.r20     = R20_W'(r20_reg);
            s3_next.clamped = 1'b0;
            abs_next        = r20_reg[MW-1] ? ROOT_W'(-r20_reg) : ROOT_W'(r20_reg);
        end
    end

    // recombine the partial products of r20^2
    assign sq_next = (RAD_W'(hh_reg) << 30) + (RAD_W'(hl_reg) << 16) + RAD_W'(ll_reg);

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= q0 * q0;
            p11_reg <= q1 * q1;
            p22_reg <= q2 * q2;
            p33_reg <= q3 * q3;
            p12_reg <= q1 * q2;
            p03_reg <= q0 * q3;
            p13_reg <= q1 * q3;
            p02_reg <= q0 * q2;
            p01_reg <= q0 * q1;
            p23_reg <= q2 * q3;

            r00_reg <= MW'(p00_reg) + MW'(p11_reg) - MW'(p22_reg) - MW'(p33_reg);
            r22_reg <= MW'(p00_reg) - MW'(p11_reg) - MW'(p22_reg) + MW'(p33_reg);
            r10_reg <= (MW'(p12_reg) + MW'(p03_reg)) <<< 1;
            r20_reg <= (MW'(p13_reg) - MW'(p02_reg)) <<< 1;
            r21_reg <= (MW'(p01_reg) + MW'(p23_reg)) <<< 1;

            s3_reg  <= s3_next;
            abs_reg <= abs_next;

            s4_reg  <= s3_reg;
            hh_reg  <= abs_reg[28:15] * abs_reg[28:15];
            hl_reg  <= abs_reg[28:15] * abs_reg[14:0];
            ll_reg  <= abs_reg[14:0] * abs_reg[14:0];

            s5_reg  <= s4_reg;
            rad_reg <= (RAD_W'(1) << 56) - sq_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign side      = s5_reg;
    assign radicand  = rad_reg;

endmodule

// ===== hdl/qte_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a payload
// carried alongside. Depends on qte_pkg.
module qte_sqrt import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  side_t              in_side,
    input  logic [RAD_W-1:0]   radicand,
    output logic               out_valid,
    output side_t              out_side,
    output logic [ROOT_W-1:0]  root
);

    logic [SQ_W-1:0] n_reg    [SQRT_STEPS];
    logic [SQ_W-1:0] root_reg [SQRT_STEPS];
    side_t           side_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] vld_reg;

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [SQ_W-1:0] n_in, root_in, trial;
        side_t side_in;

        if (k == 0)
        begin : g_first
            assign n_in    = SQ_W'(radicand);
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign n_in    = n_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = root_in + BIT;

        // subtract the trial value where it fits
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_in;
                if (n_in >= trial)
                begin
                    n_reg[k]    <= n_in - trial;
                    root_reg[k] <= (root_in >> 1) + BIT;
                end
                else
                begin
                    n_reg[k]    <= n_in;
                    root_reg[k] <= root_in >> 1;
                end
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];
    assign root      = root_reg[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== hdl/qte_cordic.sv =====
// Pipelined vectoring CORDIC atan2 with rounding to Q3.13 and saturation.
// Depends on qte_pkg.
module qte_cordic import qte_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  cordic_mode_t              mode,
    input  logic signed [MW-1:0]      y_in,
    input  logic signed [MW-1:0]      x_in,
    output logic signed [ANGLE_W-1:0] angle
);

    logic signed [CW-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STAGES+1];
    logic                 zero_reg [CORDIC_STAGES+1];
    logic signed [ANGLE_W-1:0] angle_reg;

    logic signed [CW-1:0] xs, ys;
    logic signed [ZW:0] z_wide, zz, rnd, lim;

    assign xs = CW'(x_in);
    assign ys = CW'(y_in);

    // fold the left half-plane onto the right
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -xs;
                y_reg[0] <= -ys;
                z_reg[0] <= (y_in >= 0) ? ZW'(PI_Q20) : -ZW'(PI_Q20);
            end
            else
            begin
                x_reg[0] <= xs;
                y_reg[0] <= ys;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = ZW'({1'b0, atan_q20(i)});

        // rotate toward the x axis
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
            end
        end
    end

    // negate, round Q.20 to Q3.13 and saturate
    always_comb
    begin
        z_wide = (ZW+1)'(z_reg[CORDIC_STAGES]);
        if (zero_reg[CORDIC_STAGES])
        begin
            zz = '0;
        end
        else if (mode.negate)
        begin
            zz = -z_wide;
        end
        else
        begin
            zz = z_wide;
        end
        rnd = (zz + (ZW+1)'(64)) >>> 7;
        lim = mode.half_range ? (ZW+1)'(LIMIT_HALF_PI_Q13) : (ZW+1)'(LIMIT_PI_Q13);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rnd > lim)
            begin
                angle_reg <= ANGLE_W'(lim);
            end
            else if (rnd < -lim)
            begin
                angle_reg <= ANGLE_W'(-lim);
            end
            else
            begin
                angle_reg <= ANGLE_W'(rnd);
            end
        end
    end

    assign angle = angle_reg;

endmodule

// ===== hdl/quaternion_to_euler_angles_top.sv =====
// Quaternion to Z-Y-X Euler angles, fully pipelined.
// Stages: 5 matrix stages + 29 square-root stages + CORDIC_ITERATIONS + 2 CORDIC
// stages. Throughput: one item per cycle while the output is not stalled.
// A stalled output register holds the whole pipeline; ready drops only then.
// Reset clears the valid bits only; the data registers are not reset.
// Depends on qte_pkg, qte_matrix, qte_sqrt, qte_cordic and the defines header.
`include "quaternion_to_euler_angles_top_defines.svh"
module quaternion_to_euler_angles_top import qte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // q_scalar, q_x, q_y, q_z (16 bits each)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_angle[15:0], pitch_angle[14:0], yaw_angle[15:0], 0
    output logic [0:0]  m_tuser    // asin_clamped
);

    logic en;
    logic mat_valid, sq_valid;
    side_t mat_side, sq_side;
    logic [RAD_W-1:0] radicand;
    logic [ROOT_W-1:0] root;

    logic [CORDIC_LAT-1:0] vld_reg;
    logic [CORDIC_LAT-1:0] clamp_reg;

    logic signed [ANGLE_W-1:0] roll_w, pitch_full, yaw_w;
    logic signed [PITCH_W-1:0] pitch_w;

    localparam cordic_mode_t ROLL_MODE  = '{negate: 1'b0, half_range: 1'b0};
    localparam cordic_mode_t PITCH_MODE = '{negate: 1'b1, half_range: 1'b1};
    localparam cordic_mode_t YAW_MODE   = '{negate: 1'b1, half_range: 1'b0};

    // stall everything while a result waits
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    qte_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .q0        (s_tdata[15:0]),
        .q1        (s_tdata[31:16]),
        .q2        (s_tdata[47:32]),
        .q3        (s_tdata[63:48]),
        .out_valid (mat_valid),
        .side      (mat_side),
        .radicand  (radicand)
    );

    qte_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mat_valid),
        .in_side   (mat_side),
        .radicand  (radicand),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .root      (root)
    );

    qte_cordic u_roll (
        .clk   (clk),
        .en    (en),
        .mode  (ROLL_MODE),
        .y_in  (sq_side.r21),
        .x_in  (sq_side.r22),
        .angle (roll_w)
    );

    qte_cordic u_pitch (
        .clk   (clk),
        .en    (en),
        .mode  (PITCH_MODE),
        .y_in  (MW'(sq_side.r20)),
        .x_in  ($signed({{(MW-ROOT_W){1'b0}}, root})),
        .angle (pitch_full)
    );

    qte_cordic u_yaw (
        .clk   (clk),
        .en    (en),
        .mode  (YAW_MODE),
        .y_in  (sq_side.r10),
        .x_in  (sq_side.r00),
        .angle (yaw_w)
    );

    // advance valid bits alongside the CORDIC stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[CORDIC_LAT-2:0], sq_valid};
        end
    end

    // delay the clamp flag to match
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp_reg <= {clamp_reg[CORDIC_LAT-2:0], sq_side.clamped};
        end
    end

    assign pitch_w  = pitch_full[PITCH_W-1:0];
    assign m_tvalid = vld_reg[CORDIC_LAT-1];
    assign m_tdata  = {1'b0, yaw_w, pitch_w, roll_w};
    assign m_tuser  = clamp_reg[CORDIC_LAT-1];

    `QTE_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "ready low with empty output")
    `QTE_ASSERT_IMP(a_pitch_range, m_tvalid,
        (pitch_w <= LIMIT_HALF_PI_Q13) && (pitch_w >= -LIMIT_HALF_PI_Q13), "pitch out of range")
    `QTE_ASSERT_IMP(a_roll_range, m_tvalid,
        (roll_w <= LIMIT_PI_Q13) && (roll_w >= -LIMIT_PI_Q13), "roll out of range")
    `QTE_ASSERT_IMP(a_yaw_range, m_tvalid,
        (yaw_w <= LIMIT_PI_Q13) && (yaw_w >= -LIMIT_PI_Q13), "yaw out of range")

endmodule
